// File: sv/sct_pkg.sv
// Shared types, constants and table builders for the sine and cosine interpolator.
// Depends on nothing; every other file of the block imports it.
package sct_pkg;

    localparam int ANGLE_W       = 24;
    localparam int FULL_TURN     = 360;
    localparam int HALF_TURN     = 180;
    localparam int TABLE_ENTRIES = 361;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    typedef logic signed [31:0] t_rom_tab [TABLE_ENTRIES];

    // Unsigned division by shift and subtract, used only while the tables are built.
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Pi with 60 fraction bits from Machin's formula.
    function automatic logic [63:0] f_pi60();
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] n;
        logic [63:0] k;
        logic [63:0] at5;
        logic [63:0] at239;
        logic        sub;
        at5   = '0;
        at239 = '0;
        for (int j = 0; j < 2; j++) begin
            k   = (j == 0) ? 64'd5 : 64'd239;
            t   = f_udiv(64'd1 << 60, k);
            sum = t;
            n   = 64'd1;
            sub = 1'b1;
            while (t != 64'd0) begin
                t = f_udiv(t, k * k);
                if (sub) begin
                    sum = sum - f_udiv(t, 64'd2 * n + 64'd1);
                end else begin
                    sum = sum + f_udiv(t, 64'd2 * n + 64'd1);
                end
                sub = !sub;
                n   = n + 64'd1;
            end
            if (j == 0) begin
                at5 = sum;
            end else begin
                at239 = sum;
            end
        end
        return 64'd16 * at5 - 64'd4 * at239;
    endfunction

    // Taylor series for sine or cosine with 31 fraction bits.
    function automatic logic [63:0] f_series(input logic [63:0] x, input logic want_sin);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] k;
        logic [63:0] sum;
        logic        sub;
        x2   = (x * x + (64'd1 << 30)) >> 31;
        term = want_sin ? x : (64'd1 << 31);
        k    = want_sin ? 64'd2 : 64'd1;
        sum  = term;
        sub  = 1'b1;
        for (int n = 0; n < 14; n++) begin
            term = f_udiv((term * x2) >> 31, k * (k + 64'd1));
            k    = k + 64'd2;
            if (sub) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
            sub = !sub;
        end
        return sum;
    endfunction

    function automatic logic [63:0] f_to_out(input logic [63:0] v31, input int ob);
        logic [63:0] half;
        half = (ob < 32) ? (64'd1 << (31 - ob)) : 64'd0;
        return (v31 + half) >> (32 - ob);
    endfunction

    function automatic logic signed [31:0] f_sat(input logic [63:0] mag, input logic neg,
                                                 input int ob);
        logic [63:0] maxpos;
        maxpos = (64'd1 << (ob - 1)) - 64'd1;
        if (neg) begin
            return 32'(64'd0 - mag);
        end
        return 32'((mag > maxpos) ? maxpos : mag);
    endfunction

    // Per-degree table of sine or cosine, rounded to ob bits in Q1.(ob-1).
    function automatic t_rom_tab f_build_rom(input int ob, input logic want_cos);
        t_rom_tab    tab;
        logic [63:0] rad60;
        logic [63:0] x;
        logic [63:0] smag [46];
        logic [63:0] cmag [46];
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] m;
        logic        neg;
        int          q;
        int          r;
        rad60 = f_udiv(f_pi60(), 64'(HALF_TURN));
        for (int d = 0; d <= 45; d++) begin
            x       = (rad60 * 64'(d) + (64'd1 << 28)) >> 29;
            smag[d] = f_to_out(f_series(x, 1'b1), ob);
            cmag[d] = f_to_out(f_series(x, 1'b0), ob);
        end
        q = 0;
        r = 0;
        for (int d = 0; d < TABLE_ENTRIES; d++) begin
            s = (r <= 45) ? smag[r] : cmag[90 - r];
            c = (r <= 45) ? cmag[r] : smag[90 - r];
            unique case (q & 3)
                0: begin
                    m   = want_cos ? c : s;
                    neg = 1'b0;
                end
                1: begin
                    m   = want_cos ? s : c;
                    neg = want_cos;
                end
                2: begin
                    m   = want_cos ? c : s;
                    neg = 1'b1;
                end
                default: begin
                    m   = want_cos ? s : c;
                    neg = !want_cos;
                end
            endcase
            tab[d] = f_sat(m, neg && (m != 64'd0), ob);
            if (r == 89) begin
                r = 0;
                q = q + 1;
            end else begin
                r = r + 1;
            end
        end
        return tab;
    endfunction

endpackage

// File: sv/sct_wrap.sv
// Angle reduction pipeline: wraps the angle into [0,360) degrees by a reciprocal
// multiply and yields the table index and fraction. Depends on sct_pkg.
module sct_wrap
    import sct_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int FW        = (FRAC_BITS > 0) ? FRAC_BITS : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [ANGLE_W-1:0] i_angle,
    output logic               o_valid,
    output logic [IDX_W-1:0]   o_index,
    output logic [FW-1:0]      o_frac
);

    localparam int QW  = ANGLE_W - FRAC_BITS;
    localparam int UW  = QW + 1;
    localparam int QTW = UW - 8;
    localparam int RS  = UW + 9;
    localparam longint unsigned K_OFFS =
        longint'(FULL_TURN) * ((longint'(2) ** (QW - 1) + longint'(FULL_TURN) - 1)
                               / longint'(FULL_TURN));
    localparam longint unsigned RM =
        ((64'd1 << RS) + 64'(FULL_TURN) - 64'd1) / 64'(FULL_TURN);
    localparam logic [UW-1:0] K_U  = UW'(K_OFFS);
    localparam logic [UW:0]   RM_U = (UW + 1)'(RM);
    localparam logic [8:0]    TURN = 9'(FULL_TURN);

    logic [QW-1:0]   q;
    logic [UW-1:0]   u;
    logic [FW-1:0]   f;
    logic [2*UW:0]   prod;
    logic [UW:0]     qt_turn;
    logic [UW-1:0]   rem;

    logic            r_v1;
    logic [UW-1:0]   r_u1;
    logic [FW-1:0]   r_f1;
    logic            r_v2;
    logic [UW-1:0]   r_u2;
    logic [QTW-1:0]  r_qt2;
    logic [FW-1:0]   r_f2;
    logic            r_v3;
    logic [IDX_W-1:0] r_i3;
    logic [FW-1:0]   r_f3;

    assign q       = i_angle[ANGLE_W-1:FRAC_BITS];
    assign u       = {q[QW-1], q} + K_U;
    assign f       = (FRAC_BITS > 0) ? i_angle[FW-1:0] : '0;
    assign prod    = (2 * UW + 1)'(r_u1) * (2 * UW + 1)'(RM_U);
    assign qt_turn = (UW + 1)'(r_qt2) * (UW + 1)'(TURN);
    assign rem     = r_u2 - qt_turn[UW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1  <= u;
            r_f1  <= f;
            r_u2  <= r_u1;
            r_qt2 <= prod[RS +: QTW];
            r_f2  <= r_f1;
            r_i3  <= rem[IDX_W-1:0];
            r_f3  <= r_f2;
        end
    end

    assign o_valid = r_v3;
    assign o_index = r_i3;
    assign o_frac  = r_f3;

endmodule

// File: sv/sct_rom.sv
// Per-degree sine and cosine tables with two registered read ports each.
// Depends on sct_pkg for the table builder.
module sct_rom
    import sct_pkg::*;
#(
    parameter int OUT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [IDX_W-1:0]           i_addr,
    output logic signed [OUT_BITS-1:0] o_sin_a,
    output logic signed [OUT_BITS-1:0] o_sin_b,
    output logic signed [OUT_BITS-1:0] o_cos_a,
    output logic signed [OUT_BITS-1:0] o_cos_b
);

    localparam t_rom_tab SIN_TAB = f_build_rom(OUT_BITS, 1'b0);
    localparam t_rom_tab COS_TAB = f_build_rom(OUT_BITS, 1'b1);

    logic [IDX_W-1:0] addr_b;

    assign addr_b = i_addr + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin_a <= SIN_TAB[i_addr][OUT_BITS-1:0];
            o_sin_b <= SIN_TAB[addr_b][OUT_BITS-1:0];
            o_cos_a <= COS_TAB[i_addr][OUT_BITS-1:0];
            o_cos_b <= COS_TAB[addr_b][OUT_BITS-1:0];
        end
    end

endmodule

// File: sv/sct_interp.sv
// Linear interpolation between neighbouring table entries for sine and cosine.
// Depends on sct_pkg; takes its table data from sct_rom.
module sct_interp
    import sct_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int OUT_BITS  = 16,
    parameter int FW        = (FRAC_BITS > 0) ? FRAC_BITS : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [FW-1:0]              i_frac,
    input  logic signed [OUT_BITS-1:0] i_sin_a,
    input  logic signed [OUT_BITS-1:0] i_sin_b,
    input  logic signed [OUT_BITS-1:0] i_cos_a,
    input  logic signed [OUT_BITS-1:0] i_cos_b,
    output logic                       o_valid,
    output logic [OUT_BITS-1:0]        o_sine,
    output logic [OUT_BITS-1:0]        o_cosine
);

    localparam int PW = OUT_BITS + FW + 2;
    localparam logic signed [PW-1:0] HALF = PW'((2 ** FRAC_BITS) / 2);

    logic signed [OUT_BITS:0] dsin;
    logic signed [OUT_BITS:0] dcos;
    logic signed [FW:0]       fs;
    logic signed [PW-1:0]     psin;
    logic signed [PW-1:0]     pcos;
    logic signed [PW-1:0]     ssum;
    logic signed [PW-1:0]     csum;

    logic                       r_v4;
    logic [FW-1:0]              r_f4;
    logic                       r_v5;
    logic signed [OUT_BITS-1:0] r_as5;
    logic signed [OUT_BITS-1:0] r_ac5;
    logic signed [PW-1:0]       r_ps5;
    logic signed [PW-1:0]       r_pc5;

    assign dsin = (OUT_BITS + 1)'(i_sin_b) - (OUT_BITS + 1)'(i_sin_a);
    assign dcos = (OUT_BITS + 1)'(i_cos_b) - (OUT_BITS + 1)'(i_cos_a);
    assign fs   = {1'b0, r_f4};
    assign psin = PW'(dsin) * PW'(fs) + HALF;
    assign pcos = PW'(dcos) * PW'(fs) + HALF;
    assign ssum = PW'(r_as5) + (r_ps5 >>> FRAC_BITS);
    assign csum = PW'(r_ac5) + (r_pc5 >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f4  <= i_frac;
            r_as5 <= i_sin_a;
            r_ac5 <= i_cos_a;
            r_ps5 <= psin;
            r_pc5 <= pcos;
        end
    end

    assign o_valid  = r_v5;
    assign o_sine   = ssum[OUT_BITS-1:0];
    assign o_cosine = csum[OUT_BITS-1:0];

endmodule

// File: sv/sin_cos_table_interpolator.sv
// Sine and cosine of a signed angle in degrees with FRAC_BITS fraction bits, by lookup in
// per-degree tables and linear interpolation, both results in Q1.(OUT_BITS-1) in one item.
// The block takes one item every clock cycle and holds that rate indefinitely while the
// output side keeps up; each table is read at two neighbouring entries in the same cycle,
// which sets this figure. Items pass the wrap, table and interpolation registers, then an
// output register; it and a one-item skid buffer part the two sides, so one further item
// is taken after the output stalls. Depends on sct_pkg, sct_wrap, sct_rom and sct_interp.
module sin_cos_table_interpolator
    import sct_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int OUT_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // angle [23:0]
    input  logic [ANGLE_W-1:0]                   i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // sine [OUT_BITS-1:0], cosine above it, zero padding to whole bytes
    output logic [((2 * OUT_BITS + 7) / 8) * 8-1:0] o_m_tdata
);

    localparam int FW  = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int TDW = ((2 * OUT_BITS + 7) / 8) * 8;

    logic                       en;
    logic                       wrap_valid;
    logic [IDX_W-1:0]           wrap_index;
    logic [FW-1:0]              wrap_frac;
    logic signed [OUT_BITS-1:0] sin_a;
    logic signed [OUT_BITS-1:0] sin_b;
    logic signed [OUT_BITS-1:0] cos_a;
    logic signed [OUT_BITS-1:0] cos_b;
    logic                       res_valid;
    logic [OUT_BITS-1:0]        res_sine;
    logic [OUT_BITS-1:0]        res_cosine;
    logic                       inc_v;

    logic                  r_ov;
    logic [2*OUT_BITS-1:0] r_od;
    logic                  r_sv;
    logic [2*OUT_BITS-1:0] r_sd;
    logic                  n_ov;
    logic [2*OUT_BITS-1:0] n_od;
    logic                  n_sv;
    logic [2*OUT_BITS-1:0] n_sd;

    assign en    = !r_sv;
    assign inc_v = en && res_valid;

    sct_wrap #(
        .FRAC_BITS (FRAC_BITS),
        .FW        (FW)
    ) u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_angle (i_s_tdata),
        .o_valid (wrap_valid),
        .o_index (wrap_index),
        .o_frac  (wrap_frac)
    );

    sct_rom #(
        .OUT_BITS (OUT_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_addr  (wrap_index),
        .o_sin_a (sin_a),
        .o_sin_b (sin_b),
        .o_cos_a (cos_a),
        .o_cos_b (cos_b)
    );

    sct_interp #(
        .FRAC_BITS (FRAC_BITS),
        .OUT_BITS  (OUT_BITS),
        .FW        (FW)
    ) u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (wrap_valid),
        .i_frac   (wrap_frac),
        .i_sin_a  (sin_a),
        .i_sin_b  (sin_b),
        .i_cos_a  (cos_a),
        .i_cos_b  (cos_b),
        .o_valid  (res_valid),
        .o_sine   (res_sine),
        .o_cosine (res_cosine)
    );

    always_comb begin
        n_ov = r_ov;
        n_od = r_od;
        n_sv = r_sv;
        n_sd = r_sd;
        if (!r_ov || i_m_tready) begin
            if (r_sv) begin
                n_ov = 1'b1;
                n_od = r_sd;
                n_sv = 1'b0;
            end else begin
                n_ov = inc_v;
                n_od = {res_cosine, res_sine};
            end
        end else if (inc_v) begin
            n_sv = 1'b1;
            n_sd = {res_cosine, res_sine};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od <= n_od;
        r_sd <= n_sd;
    end

    assign o_s_tready = en;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = TDW'(r_od);

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for sin_cos_table_interpolator: directed and random angles,
// checked against a table and interpolation predictor built here from first principles.
// Depends on sct_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
    import sct_pkg::*;

    localparam int FRAC_W      = 8;
    localparam int OUT_W       = 16;
    localparam int TURN_FIXED  = FULL_TURN << FRAC_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [OUT_W-1:0] cosine;
        logic [OUT_W-1:0] sine;
    } t_sin_cos;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_valid = 1'b0;
    logic               o_s_tready;
    // angle [23:0]
    logic [ANGLE_W-1:0] s_data = '0;
    logic               o_m_tvalid;
    logic               m_ready = 1'b0;
    // sine [15:0], cosine [31:16]
    logic [31:0]        o_m_tdata;

    int       sin_deg [TABLE_ENTRIES];
    int       cos_deg [TABLE_ENTRIES];
    t_sin_cos pending_sin_cos [$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    bit       src_pace = 1'b1;
    bit       snk_pace = 1'b1;

    sin_cos_table_interpolator #(
        .FRAC_BITS (FRAC_W),
        .OUT_BITS  (OUT_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Arctangent of 1/k with 60 fraction bits, by its alternating series.
    function automatic logic [63:0] arctan_recip(input logic [63:0] k);
        logic [63:0] t;
        logic [63:0] acc;
        logic [63:0] n;
        bit          subtract;
        t        = (64'd1 << 60) / k;
        acc      = t;
        n        = 64'd1;
        subtract = 1'b1;
        while (t != 64'd0) begin
            t = t / (k * k);
            if (subtract) begin
                acc = acc - t / (64'd2 * n + 64'd1);
            end else begin
                acc = acc + t / (64'd2 * n + 64'd1);
            end
            subtract = !subtract;
            n        = n + 64'd1;
        end
        return acc;
    endfunction

    // Taylor sum for sine or cosine of x in radians, 31 fraction bits in and out.
    function automatic logic [63:0] taylor_trig(input logic [63:0] x, input bit is_sine);
        logic [63:0] x_sq;
        logic [63:0] term;
        logic [63:0] k;
        logic [63:0] acc;
        bit          subtract;
        x_sq     = (x * x + (64'd1 << 30)) >> 31;
        term     = is_sine ? x : (64'd1 << 31);
        k        = is_sine ? 64'd2 : 64'd1;
        acc      = term;
        subtract = 1'b1;
        for (int n = 0; n < 14; n++) begin
            term = ((term * x_sq) >> 31) / (k * (k + 64'd1));
            k    = k + 64'd2;
            if (subtract) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
            subtract = !subtract;
        end
        return acc;
    endfunction

    function automatic int apply_sign(input logic [63:0] mag, input bit negative);
        if (negative && mag != 64'd0) begin
            return -int'(mag);
        end
        return (mag > 64'd32767) ? 32767 : int'(mag);
    endfunction

    // Per-degree tables: the first octant is computed, the rest follows by symmetry.
    function automatic void build_degree_tables();
        logic [63:0] rad_per_deg;
        logic [63:0] x;
        logic [63:0] sin_mag [46];
        logic [63:0] cos_mag [46];
        logic [63:0] sm;
        logic [63:0] cm;
        int          r;
        rad_per_deg = (64'd16 * arctan_recip(64'd5) - 64'd4 * arctan_recip(64'd239))
                      / 64'(HALF_TURN);
        for (int d = 0; d <= 45; d++) begin
            x          = (rad_per_deg * 64'(d) + (64'd1 << 28)) >> 29;
            sin_mag[d] = (taylor_trig(x, 1'b1) + (64'd1 << 15)) >> 16;
            cos_mag[d] = (taylor_trig(x, 1'b0) + (64'd1 << 15)) >> 16;
        end
        for (int d = 0; d < TABLE_ENTRIES; d++) begin
            r  = d % 90;
            sm = (r <= 45) ? sin_mag[r] : cos_mag[90 - r];
            cm = (r <= 45) ? cos_mag[r] : sin_mag[90 - r];
            case ((d / 90) % 4)
                0: begin
                    sin_deg[d] = apply_sign(sm, 1'b0);
                    cos_deg[d] = apply_sign(cm, 1'b0);
                end
                1: begin
                    sin_deg[d] = apply_sign(cm, 1'b0);
                    cos_deg[d] = apply_sign(sm, 1'b1);
                end
                2: begin
                    sin_deg[d] = apply_sign(sm, 1'b1);
                    cos_deg[d] = apply_sign(cm, 1'b1);
                end
                default: begin
                    sin_deg[d] = apply_sign(cm, 1'b1);
                    cos_deg[d] = apply_sign(sm, 1'b0);
                end
            endcase
        end
    endfunction

    function automatic t_sin_cos predict_sin_cos(input logic [ANGLE_W-1:0] angle);
        longint   wrapped;
        longint   idx;
        longint   frac;
        longint   sv;
        longint   cv;
        t_sin_cos res;
        wrapped = longint'($signed(angle)) % longint'(TURN_FIXED);
        if (wrapped < 0) begin
            wrapped = wrapped + TURN_FIXED;
        end
        idx  = wrapped >>> FRAC_W;
        frac = wrapped & ((64'sd1 <<< FRAC_W) - 1);
        sv   = sin_deg[idx] + ((frac * (sin_deg[idx + 1] - sin_deg[idx])
               + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W);
        cv   = cos_deg[idx] + ((frac * (cos_deg[idx + 1] - cos_deg[idx])
               + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W);
        res.sine   = sv[OUT_W-1:0];
        res.cosine = cv[OUT_W-1:0];
        return res;
    endfunction

    task automatic send_angle(input logic [ANGLE_W-1:0] angle);
        int gap;
        gap = src_pace ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= angle;
        do @(posedge i_clk); while (!o_s_tready);
        pending_sin_cos.push_back(predict_sin_cos(angle));
    endtask

    function automatic logic [ANGLE_W-1:0] as_angle(input longint value);
        return value[ANGLE_W-1:0];
    endfunction

    task automatic test_quadrant_points();
        send_angle(as_angle(0));
        send_angle(as_angle(45 * 256));
        send_angle(as_angle(90 * 256));
        send_angle(as_angle(135 * 256));
        send_angle(as_angle(180 * 256));
        send_angle(as_angle(225 * 256));
        send_angle(as_angle(270 * 256));
        send_angle(as_angle(315 * 256));
        send_angle(as_angle(359 * 256));
        send_angle(as_angle(TURN_FIXED - 1));
        send_angle(as_angle(1));
        send_angle(as_angle(128));
        send_angle(as_angle(89 * 256 + 255));
    endtask

    task automatic test_wrap_and_extremes();
        send_angle(as_angle(TURN_FIXED));
        send_angle(as_angle(-TURN_FIXED));
        send_angle(as_angle(3 * TURN_FIXED));
        send_angle(as_angle(-1));
        send_angle(as_angle(-128));
        send_angle(as_angle(-90 * 256));
        send_angle(as_angle(-2 * TURN_FIXED + 5));
        send_angle(as_angle(8388607));
        send_angle(as_angle(-8388608));
        send_angle(as_angle(91 * TURN_FIXED));
    endtask

    // Mixed angles in segments, each with its own pacing on both sides.
    task automatic test_random_angles(input int count);
        int     kind;
        longint value;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                src_pace = ($urandom_range(0, 3) != 0);
                snk_pace = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                value = longint'($urandom_range(0, 32'hFFFFFF));
            end else if (kind < 7) begin
                value = longint'($urandom_range(0, 4 * TURN_FIXED)) - 2 * TURN_FIXED;
            end else if (kind < 9) begin
                value = (longint'($urandom_range(0, 720)) - 360) * 256;
            end else begin
                value = (longint'($urandom_range(0, 180)) - 90) * TURN_FIXED
                        + longint'($urandom_range(0, 4)) - 2;
            end
            send_angle(as_angle(value));
        end
    endtask

    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = snk_pace ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_sin_cos want;
        t_sin_cos got;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            got = o_m_tdata;
            if (pending_sin_cos.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("Unexpected item: sine %0d cosine %0d",
                             $signed(got.sine), $signed(got.cosine));
                end
            end else begin
                want = pending_sin_cos.pop_front();
                if (got.sine !== want.sine || got.cosine !== want.cosine) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Mismatch: sine exp %0d got %0d, cosine exp %0d got %0d",
                                 $signed(want.sine), $signed(got.sine),
                                 $signed(want.cosine), $signed(got.cosine));
                    end
                end
            end
        end
    end

    initial begin
        build_degree_tables();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_quadrant_points();
        test_wrap_and_extremes();
        test_random_angles(1000);
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_sin_cos.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_sin_cos.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
sv/sct_pkg.sv
sv/sct_wrap.sv
sv/sct_rom.sv
sv/sct_interp.sv
sv/sin_cos_table_interpolator.sv
verif/tb_top.sv
